FILE: design/jtl_pkg.sv
// shared types, codes and literal tables of the json token lexer
package jtl_pkg;

  // output queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // token kinds
  localparam logic [3:0] KIND_LBRACK  = 4'd0;
  localparam logic [3:0] KIND_RBRACK  = 4'd1;
  localparam logic [3:0] KIND_LBRACE  = 4'd2;
  localparam logic [3:0] KIND_RBRACE  = 4'd3;
  localparam logic [3:0] KIND_COLON   = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_NUMTEXT = 4'd7;
  localparam logic [3:0] KIND_INTEGER = 4'd8;
  localparam logic [3:0] KIND_FLOAT   = 4'd9;
  localparam logic [3:0] KIND_BOOLEAN = 4'd10;
  localparam logic [3:0] KIND_NULL    = 4'd11;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MINUS    = 3'd1;
  localparam logic [2:0] ERR_NUMBER   = 3'd2;
  localparam logic [2:0] ERR_STRING   = 3'd3;
  localparam logic [2:0] ERR_BOOLEAN  = 3'd4;
  localparam logic [2:0] ERR_NULL     = 3'd5;

  // characters
  localparam logic [7:0] CH_LBRACK    = 8'h5B;
  localparam logic [7:0] CH_RBRACK    = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;

  // literal selectors
  localparam logic [1:0] LIT_TRUE     = 2'd0;
  localparam logic [1:0] LIT_FALSE    = 2'd1;
  localparam logic [1:0] LIT_NULL     = 2'd2;

  // number flag bits
  localparam int NF_LEADZ = 0;
  localparam int NF_MORE  = 1;
  localparam int NF_DOT   = 2;
  localparam int NF_FRAC  = 3;
  localparam int NF_DOT2  = 4;

  // string flag bits
  localparam int SF_ODD     = 0;
  localparam int SF_STARTED = 1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MINUS,
    MODE_NUMBER,
    MODE_STRING,
    MODE_LITERAL,
    MODE_ERROR
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic       has_byte;
    logic [7:0] text_byte;
    logic       token_start;
    logic       token_end;
    logic       literal_true;
    logic [2:0] error_code;
    logic       last_of_item;
  } out_item_t;

  typedef struct packed {
    mode_e      mode;
    logic [4:0] nflags;
    logic [1:0] sflags;
    logic [2:0] lpos;
    logic [1:0] lwhich;
  } lex_state_t;

  function automatic out_item_t mk_res(logic [3:0] kind, logic has, logic [7:0] b,
                                       logic start, logic tok_end, logic lit,
                                       logic [2:0] err);
    out_item_t r;
    r.token_kind   = kind;
    r.has_byte     = has;
    r.text_byte    = b;
    r.token_start  = start;
    r.token_end    = tok_end;
    r.literal_true = lit;
    r.error_code   = err;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] w);
    logic [2:0] len;
    case (w)
      LIT_TRUE:  len = 3'd4;
      LIT_FALSE: len = 3'd5;
      default:   len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] p);
    logic [7:0] c;
    case ({w, p})
      {LIT_TRUE,  3'd0}: c = 8'h74;
      {LIT_TRUE,  3'd1}: c = 8'h72;
      {LIT_TRUE,  3'd2}: c = 8'h75;
      {LIT_TRUE,  3'd3}: c = 8'h65;
      {LIT_FALSE, 3'd0}: c = 8'h66;
      {LIT_FALSE, 3'd1}: c = 8'h61;
      {LIT_FALSE, 3'd2}: c = 8'h6C;
      {LIT_FALSE, 3'd3}: c = 8'h73;
      {LIT_FALSE, 3'd4}: c = 8'h65;
      {LIT_NULL,  3'd0}: c = 8'h6E;
      {LIT_NULL,  3'd1}: c = 8'h75;
      {LIT_NULL,  3'd2}: c = 8'h6C;
      {LIT_NULL,  3'd3}: c = 8'h6C;
      default:           c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: design/jtl_step.sv
// next-state and result logic for one input item of the lexer
module jtl_step (
  input  jtl_pkg::in_item_t   item_i,
  input  jtl_pkg::lex_state_t state_i,
  output jtl_pkg::lex_state_t state_o,
  output jtl_pkg::out_item_t  res0_o,
  output jtl_pkg::out_item_t  res1_o,
  output logic [1:0]          count_o
);
  import jtl_pkg::*;

  typedef struct packed {
    logic       put;
    out_item_t  res;
    lex_state_t st;
  } idle_out_t;

  // byte seen outside any token
  function automatic idle_out_t idle_byte(lex_state_t s, logic [7:0] b);
    idle_out_t o;
    o.put = 1'b0;
    o.res = '0;
    o.st  = s;
    case (b)
      CH_LBRACK: begin
        o.put = 1'b1;
        o.res = mk_res(KIND_LBRACK, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      CH_RBRACK: begin
        o.put = 1'b1;
        o.res = mk_res(KIND_RBRACK, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      CH_LBRACE: begin
        o.put = 1'b1;
        o.res = mk_res(KIND_LBRACE, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      CH_RBRACE: begin
        o.put = 1'b1;
        o.res = mk_res(KIND_RBRACE, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      CH_COLON: begin
        o.put = 1'b1;
        o.res = mk_res(KIND_COLON, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      CH_COMMA: begin
        o.put = 1'b1;
        o.res = mk_res(KIND_COMMA, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      CH_QUOTE: begin
        o.st.mode   = MODE_STRING;
        o.st.sflags = '0;
      end
      CH_T: begin
        o.st.mode   = MODE_LITERAL;
        o.st.lwhich = LIT_TRUE;
        o.st.lpos   = 3'd1;
      end
      CH_F: begin
        o.st.mode   = MODE_LITERAL;
        o.st.lwhich = LIT_FALSE;
        o.st.lpos   = 3'd1;
      end
      CH_N: begin
        o.st.mode   = MODE_LITERAL;
        o.st.lwhich = LIT_NULL;
        o.st.lpos   = 3'd1;
      end
      CH_MINUS: begin
        o.st.mode = MODE_MINUS;
      end
      default: begin
        if (is_digit(b)) begin
          o.st.mode   = MODE_NUMBER;
          o.st.nflags = (b == CH_ZERO) ? 5'b00001 : 5'b00000;
          o.put       = 1'b1;
          o.res       = mk_res(KIND_NUMTEXT, 1'b1, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
        end
      end
    endcase
    return o;
  endfunction

  logic [7:0] b;
  logic [4:0] nf;
  logic       num_bad;
  logic [1:0] w;
  logic [2:0] wlen;
  logic [2:0] p_next;
  logic       lit_miss;
  out_item_t  lit_err;
  idle_out_t  io_idle;
  idle_out_t  io_close;
  lex_state_t st_close;
  out_item_t  r0;
  out_item_t  r1;
  logic [1:0] n;
  lex_state_t st;

  assign b       = item_i.in_byte;
  assign nf      = state_i.nflags;
  assign num_bad = (nf[NF_LEADZ] && nf[NF_MORE]) || nf[NF_DOT2] ||
                   (nf[NF_DOT] && !nf[NF_FRAC]);
  assign w       = (state_i.lwhich > LIT_NULL) ? LIT_NULL : state_i.lwhich;
  assign wlen    = lit_len(w);
  assign p_next  = state_i.lpos + 3'd1;
  assign lit_miss = (state_i.lpos >= wlen) || (b != lit_char(w, state_i.lpos));
  assign lit_err = (w == LIT_NULL) ?
                   mk_res(KIND_NULL, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NULL) :
                   mk_res(KIND_BOOLEAN, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_BOOLEAN);

  // state after a well formed number closes, before the closing byte is decoded
  always_comb begin
    st_close        = state_i;
    st_close.mode   = MODE_IDLE;
    st_close.nflags = '0;
  end

  assign io_idle  = idle_byte(state_i, b);
  assign io_close = idle_byte(st_close, b);

  always_comb begin
    st = state_i;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (item_i.end_of_input) begin
      case (state_i.mode)
        MODE_NUMBER: begin
          n = 2'd1;
          if (num_bad) begin
            r0 = mk_res(KIND_NUMTEXT, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NUMBER);
          end else begin
            r0 = mk_res(nf[NF_DOT] ? KIND_FLOAT : KIND_INTEGER, 1'b0, 8'h00,
                        1'b0, 1'b1, 1'b0, ERR_NONE);
          end
        end
        MODE_MINUS: begin
          n  = 2'd1;
          r0 = mk_res(KIND_NUMTEXT, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_MINUS);
        end
        MODE_STRING: begin
          n  = 2'd1;
          r0 = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_STRING);
        end
        MODE_LITERAL: begin
          n  = 2'd1;
          r0 = lit_err;
        end
        default: begin
          n = 2'd0;
        end
      endcase
      st      = '0;
      st.mode = MODE_IDLE;
    end else begin
      case (state_i.mode)
        MODE_IDLE: begin
          n  = {1'b0, io_idle.put};
          r0 = io_idle.res;
          st = io_idle.st;
        end
        MODE_MINUS: begin
          if (is_digit(b)) begin
            n         = 2'd2;
            r0        = mk_res(KIND_NUMTEXT, 1'b1, CH_MINUS, 1'b1, 1'b0, 1'b0, ERR_NONE);
            r1        = mk_res(KIND_NUMTEXT, 1'b1, b, 1'b0, 1'b0, 1'b0, ERR_NONE);
            st.mode   = MODE_NUMBER;
            st.nflags = (b == CH_ZERO) ? 5'b00001 : 5'b00000;
          end else begin
            n       = 2'd1;
            r0      = mk_res(KIND_NUMTEXT, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_MINUS);
            st.mode = MODE_ERROR;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(b)) begin
            n = 2'd1;
            r0 = mk_res(KIND_NUMTEXT, 1'b1, b, 1'b0, 1'b0, 1'b0, ERR_NONE);
            if (nf[NF_DOT]) begin
              st.nflags[NF_FRAC] = 1'b1;
            end else begin
              st.nflags[NF_MORE] = 1'b1;
            end
          end else if (b == CH_DOT) begin
            n = 2'd1;
            r0 = mk_res(KIND_NUMTEXT, 1'b1, b, 1'b0, 1'b0, 1'b0, ERR_NONE);
            if (nf[NF_DOT]) begin
              st.nflags[NF_DOT2] = 1'b1;
            end else begin
              st.nflags[NF_DOT] = 1'b1;
            end
          end else if (num_bad) begin
            // closing byte is swallowed by the error mode
            n         = 2'd1;
            r0        = mk_res(KIND_NUMTEXT, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NUMBER);
            st.mode   = MODE_ERROR;
            st.nflags = '0;
          end else begin
            // close the number, then decode the byte as outside a token
            r0 = mk_res(nf[NF_DOT] ? KIND_FLOAT : KIND_INTEGER, 1'b0, 8'h00,
                        1'b0, 1'b1, 1'b0, ERR_NONE);
            r1 = io_close.res;
            n  = io_close.put ? 2'd2 : 2'd1;
            st = io_close.st;
          end
        end
        MODE_STRING: begin
          n = 2'd1;
          if ((b == CH_QUOTE) && !state_i.sflags[SF_ODD]) begin
            r0        = mk_res(KIND_STRING, 1'b0, 8'h00, !state_i.sflags[SF_STARTED],
                               1'b1, 1'b0, ERR_NONE);
            st.sflags = '0;
            st.mode   = MODE_IDLE;
          end else begin
            r0 = mk_res(KIND_STRING, 1'b1, b, !state_i.sflags[SF_STARTED],
                        1'b0, 1'b0, ERR_NONE);
            if (b == CH_BACKSLASH) begin
              st.sflags = {1'b1, !state_i.sflags[SF_ODD]};
            end else begin
              st.sflags = 2'b10;
            end
          end
        end
        MODE_LITERAL: begin
          if (lit_miss) begin
            n       = 2'd1;
            r0      = lit_err;
            st.mode = MODE_ERROR;
          end else if (p_next == wlen) begin
            n = 2'd1;
            if (w == LIT_NULL) begin
              r0 = mk_res(KIND_NULL, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end else begin
              r0 = mk_res(KIND_BOOLEAN, 1'b0, 8'h00, 1'b1, 1'b1, w == LIT_TRUE, ERR_NONE);
            end
            st.mode   = MODE_IDLE;
            st.lpos   = '0;
            st.lwhich = '0;
          end else begin
            st.lpos = p_next;
          end
        end
        default: begin
          // sticky error: bytes ignored until end of input
          n = 2'd0;
        end
      endcase
    end
    r0.last_of_item = (n == 2'd1);
    r1.last_of_item = 1'b1;
  end

  assign state_o = st;
  assign res0_o  = r0;
  assign res1_o  = r1;
  assign count_o = n;

endmodule

FILE: design/jtl_outq.sv
// small result queue taking up to two results per cycle and giving one
module jtl_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_cnt_i,
  input  jtl_pkg::out_item_t push0_i,
  input  jtl_pkg::out_item_t push1_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output jtl_pkg::out_item_t data_o
);
  import jtl_pkg::*;

  out_item_t          mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_q, wr_d;
  logic [OQ_AW-1:0]   rd_q, rd_d;
  logic [OQ_CW-1:0]   cnt_q, cnt_d;
  logic [OQ_AW-1:0]   wr_next;
  logic               pop;

  assign pop     = valid_o && ready_i;
  assign wr_next = wr_q + OQ_AW'(1);
  assign wr_d    = wr_q + OQ_AW'(push_cnt_i);
  assign rd_d    = pop ? rd_q + OQ_AW'(1) : rd_q;
  assign cnt_d   = cnt_q + OQ_CW'(push_cnt_i) - OQ_CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

  // two free slots needed so the worst-case item always fits
  assign room_o  = cnt_q <= OQ_CW'(OQ_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

endmodule

FILE: design/json_token_lexer.sv
// top level of the json token lexer: input register, step logic, result queue
//
// usage
//   input channel: one JSON text byte per transfer (in_byte), or an end marker
//   (end_of_input) that flushes any open token and returns the lexer to idle
//   output channel: one result per transfer; an input item gives zero, one or
//   two results and the last one of an item carries last_of_item
//   throughput: one input item per cycle as long as results drain at the rate
//   they are produced; an item giving two results needs two output transfers
//   path: an input item waits in the input register until the step logic takes
//   it, its results are then written into the result queue, and the first of
//   them is offered on the output channel from the queue
//   the input register feeds the step logic once the four-entry result queue
//   has room for two results, which is what sets the input-side stall
//   stall: when the receiver holds ready low the queue fills and in_ready_o
//   drops after the input register is occupied; nothing is lost or repeated
//   reset: asynchronous, active low; lexer returns to idle with empty queue
//   and empty input register, so no result is pending after reset
module json_token_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jtl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jtl_pkg::out_item_t out_data_o
);
  import jtl_pkg::*;

  // input register
  in_item_t   in_q;
  logic       in_vld_q, in_vld_d;
  logic       in_take;

  // lexer state
  lex_state_t state_q, state_d;
  lex_state_t step_state;

  // step results
  out_item_t  step_r0;
  out_item_t  step_r1;
  logic [1:0] step_cnt;

  // queue control
  logic       q_room;
  logic       proc;
  logic [1:0] push_cnt;

  // an item in the register is processed when the queue can take two results
  assign proc       = in_vld_q && q_room;
  assign in_ready_o = !in_vld_q || proc;
  assign in_take    = in_valid_i && in_ready_o;
  assign in_vld_d   = in_take ? 1'b1 : (proc ? 1'b0 : in_vld_q);
  assign push_cnt   = proc ? step_cnt : 2'd0;
  assign state_d    = proc ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '{mode: MODE_IDLE, default: '0};
    end else begin
      in_vld_q <= in_vld_d;
      state_q  <= state_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  jtl_step u_step (
    .item_i  (in_q),
    .state_i (state_q),
    .state_o (step_state),
    .res0_o  (step_r0),
    .res1_o  (step_r1),
    .count_o (step_cnt)
  );

  jtl_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (step_r0),
    .push1_i    (step_r1),
    .room_o     (q_room),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_data_o)
  );

  // a held item that cannot be processed stays put
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proc |=> in_vld_q && $stable(in_q))
    else $error("held input item lost or changed");

  // end marker always returns the lexer to idle
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.end_of_input |=> state_q.mode == MODE_IDLE)
    else $error("end of input did not return lexer to idle");

  // sticky error gives no result for data bytes
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (state_q.mode == MODE_ERROR) && !in_q.end_of_input |-> step_cnt == 2'd0)
    else $error("result produced in error mode");

  // only the final result of an item is marked last
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (step_cnt == 2'd2) |-> step_r1.last_of_item && !step_r0.last_of_item)
    else $error("last_of_item misplaced on two-result item");

endmodule
